@@ rtl/vsi_pkg.sv @@
// Shared types and constants for the vehicle safety interlock.
package vsi_pkg;

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_NAV_BEAT  = 3'd1,
        KIND_NAV_EXIT  = 3'd2,
        KIND_NAV_CMD   = 3'd3,
        KIND_SENSOR    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REFUSE_OK        = 3'd0,
        REFUSE_OVERSPEED = 3'd1,
        REFUSE_OVERSTEER = 3'd2,
        REFUSE_SENSOR    = 3'd3,
        REFUSE_RECOVERY  = 3'd4,
        REFUSE_LOCKED    = 3'd5
    } refusal_t;

    typedef enum logic [2:0] {
        MODE_NORMAL    = 3'd0,
        MODE_NO_SENSOR = 3'd1,
        MODE_RECOVERY  = 3'd2,
        MODE_SHAKING   = 3'd3,
        MODE_LOCKED    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        REG_SPEED_LIMIT    = 3'd0,
        REG_STEERING_LIMIT = 3'd1,
        REG_MIN_DISTANCE   = 3'd2,
        REG_SILENCE_LIMIT  = 3'd3,
        REG_CHECK_PERIOD   = 3'd4,
        REG_REST_LIMIT     = 3'd5,
        REG_HOLD           = 3'd6
    } reg_index_t;

    // Notice mask bit positions
    localparam int NOTICE_SLOW   = 0;
    localparam int NOTICE_RESUME = 1;
    localparam int NOTICE_STOP   = 2;
    localparam int NOTICE_LOCK   = 3;

    localparam logic [14:0] SPEED_LIMIT_RST    = 15'd512;
    localparam logic [14:0] STEERING_LIMIT_RST = 15'd6400;
    localparam logic [15:0] MIN_DISTANCE_RST   = 16'd160;
    localparam logic [15:0] SILENCE_LIMIT_RST  = 16'd500;
    localparam logic [15:0] CHECK_PERIOD_RST   = 16'd200;
    localparam logic [15:0] REST_LIMIT_RST     = 16'd5000;
    localparam logic [15:0] HOLD_RST           = 16'd3000;

    localparam logic [15:0] SAT16 = 16'hFFFF;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 80;

endpackage

@@ rtl/vehicle_safety_interlock_unit.sv @@
// Safety supervisor: approves navigation commands and watches partner timers.
// Path from item accepted to result valid: input register, then result register.
// Throughput: one item per cycle while m_tready is held high; the state update and result are formed in one pass.
// Reset: asynchronous active-low; all supervisor state and counters clear, the
// configuration registers return to their default limits.
module vehicle_safety_interlock_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // speed[15:0], steering[31:16], imu_ok[32], ranger_ok[33], distance[49:34],
    // shaking[50], zero pad
    input  logic [vsi_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // approved[0], refusal[3:1], nav_notice[7:4], alive_pulse[8], safe_lamp[9],
    // mode[12:10], approved_total[44:13], rejected_total[76:45], zero pad
    output logic [vsi_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    // Configuration
    logic [14:0] speed_limit_reg;
    logic [14:0] steering_limit_reg;
    logic [15:0] min_distance_reg;
    logic [15:0] silence_limit_reg;
    logic [15:0] check_period_reg;
    logic [15:0] rest_limit_reg;
    logic [15:0] hold_ms_reg;

    // Supervisor state
    logic        nav_contact_reg,   nav_contact_next;
    logic        sensor_seen_reg,   sensor_seen_next;
    logic        recovering_reg,    recovering_next;
    logic        shake_wait_reg,    shake_wait_next;
    logic        lock_flag_reg,     lock_flag_next;
    logic        snap_imu_reg,      snap_imu_next;
    logic        snap_ranger_reg,   snap_ranger_next;
    logic [15:0] snap_dist_reg,     snap_dist_next;
    logic [15:0] nav_quiet_reg,     nav_quiet_next;
    logic [15:0] sensor_quiet_reg,  sensor_quiet_next;
    logic [15:0] check_phase_reg,   check_phase_next;
    logic [15:0] rest_left_reg,     rest_left_next;
    logic [15:0] hold_left_reg,     hold_left_next;
    logic [31:0] approve_count_reg, approve_count_next;
    logic [31:0] reject_count_reg,  reject_count_next;

    // Input stage
    logic        in_valid_reg;
    logic [2:0]  in_kind_reg;
    logic [15:0] in_speed_reg;
    logic [15:0] in_steering_reg;
    logic        in_imu_reg;
    logic        in_ranger_reg;
    logic [15:0] in_distance_reg;
    logic        in_shaking_reg;

    // Result stage
    logic                            out_valid_reg;
    logic [vsi_pkg::OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg    <= vsi_pkg::SPEED_LIMIT_RST;
            steering_limit_reg <= vsi_pkg::STEERING_LIMIT_RST;
            min_distance_reg   <= vsi_pkg::MIN_DISTANCE_RST;
            silence_limit_reg  <= vsi_pkg::SILENCE_LIMIT_RST;
            check_period_reg   <= vsi_pkg::CHECK_PERIOD_RST;
            rest_limit_reg     <= vsi_pkg::REST_LIMIT_RST;
            hold_ms_reg        <= vsi_pkg::HOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (vsi_pkg::reg_index_t'(cfg_addr))
                vsi_pkg::REG_SPEED_LIMIT:    speed_limit_reg    <= cfg_data[14:0];
                vsi_pkg::REG_STEERING_LIMIT: steering_limit_reg <= cfg_data[14:0];
                vsi_pkg::REG_MIN_DISTANCE:   min_distance_reg   <= cfg_data;
                vsi_pkg::REG_SILENCE_LIMIT:  silence_limit_reg  <= cfg_data;
                vsi_pkg::REG_CHECK_PERIOD:   check_period_reg   <= cfg_data;
                vsi_pkg::REG_REST_LIMIT:     rest_limit_reg     <= cfg_data;
                vsi_pkg::REG_HOLD:           hold_ms_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg     <= s_tuser;
            in_speed_reg    <= s_tdata[15:0];
            in_steering_reg <= s_tdata[31:16];
            in_imu_reg      <= s_tdata[32];
            in_ranger_reg   <= s_tdata[33];
            in_distance_reg <= s_tdata[49:34];
            in_shaking_reg  <= s_tdata[50];
        end
    end

    always_comb
    begin
        logic [15:0]        rest_dec;
        logic [15:0]        hold_dec;
        logic               alive;
        logic               approved;
        logic [3:0]         notice;
        vsi_pkg::refusal_t  refusal;
        vsi_pkg::mode_t     mode;
        logic signed [16:0] steer_s;
        logic signed [16:0] lim_s;

        nav_contact_next   = nav_contact_reg;
        sensor_seen_next   = sensor_seen_reg;
        recovering_next    = recovering_reg;
        shake_wait_next    = shake_wait_reg;
        lock_flag_next     = lock_flag_reg;
        snap_imu_next      = snap_imu_reg;
        snap_ranger_next   = snap_ranger_reg;
        snap_dist_next     = snap_dist_reg;
        nav_quiet_next     = nav_quiet_reg;
        sensor_quiet_next  = sensor_quiet_reg;
        check_phase_next   = check_phase_reg;
        rest_left_next     = rest_left_reg;
        hold_left_next     = hold_left_reg;
        approve_count_next = approve_count_reg;
        reject_count_next  = reject_count_reg;

        rest_dec = rest_left_reg - 16'd1;
        hold_dec = hold_left_reg - 16'd1;
        alive    = 1'b0;
        approved = 1'b0;
        notice   = 4'd0;
        refusal  = vsi_pkg::REFUSE_OK;
        steer_s  = {in_steering_reg[15], in_steering_reg};
        lim_s    = {2'b00, steering_limit_reg};

        case (vsi_pkg::kind_t'(in_kind_reg))
            vsi_pkg::KIND_TICK:
            begin
                nav_quiet_next    = (nav_quiet_reg == vsi_pkg::SAT16) ? vsi_pkg::SAT16
                                    : nav_quiet_reg + 16'd1;
                sensor_quiet_next = (sensor_quiet_reg == vsi_pkg::SAT16) ? vsi_pkg::SAT16
                                    : sensor_quiet_reg + 16'd1;
                check_phase_next  = (check_phase_reg == vsi_pkg::SAT16) ? vsi_pkg::SAT16
                                    : check_phase_reg + 16'd1;
                if (rest_left_reg != 16'd0)
                begin
                    rest_left_next = rest_dec;
                    if (rest_dec == 16'd0 && shake_wait_reg)
                    begin
                        shake_wait_next = 1'b0;
                        lock_flag_next  = 1'b1;
                        notice[vsi_pkg::NOTICE_LOCK] = 1'b1;
                    end
                end
                if (hold_left_reg != 16'd0)
                begin
                    hold_left_next = hold_dec;
                    if (hold_dec == 16'd0)
                    begin
                        recovering_next = 1'b0;
                    end
                end
                if (check_phase_next >= check_period_reg)
                begin
                    check_phase_next = 16'd0;
                    alive            = 1'b1;
                    if (shake_wait_next || lock_flag_next || !sensor_seen_reg)
                    begin
                        hold_left_next = hold_ms_reg;
                    end
                    if (nav_contact_reg && nav_quiet_next > silence_limit_reg)
                    begin
                        recovering_next  = 1'b1;
                        hold_left_next   = hold_ms_reg;
                        nav_contact_next = 1'b0;
                    end
                    if (sensor_seen_reg && sensor_quiet_next > silence_limit_reg)
                    begin
                        recovering_next  = 1'b1;
                        hold_left_next   = hold_ms_reg;
                        sensor_seen_next = 1'b0;
                        notice[vsi_pkg::NOTICE_STOP] = 1'b1;
                    end
                end
            end
            vsi_pkg::KIND_NAV_BEAT:
            begin
                nav_quiet_next   = 16'd0;
                nav_contact_next = 1'b1;
            end
            vsi_pkg::KIND_NAV_EXIT:
            begin
                nav_contact_next = 1'b0;
            end
            vsi_pkg::KIND_NAV_CMD:
            begin
                if (lock_flag_reg)
                    refusal = vsi_pkg::REFUSE_LOCKED;
                else if (recovering_reg)
                    refusal = vsi_pkg::REFUSE_RECOVERY;
                else if ($signed(in_speed_reg) > $signed({1'b0, speed_limit_reg}))
                    refusal = vsi_pkg::REFUSE_OVERSPEED;
                else if (steer_s > lim_s || steer_s < -lim_s)
                    refusal = vsi_pkg::REFUSE_OVERSTEER;
                else if (!sensor_seen_reg || !snap_imu_reg || !snap_ranger_reg ||
                         snap_dist_reg <= min_distance_reg)
                    refusal = vsi_pkg::REFUSE_SENSOR;
                else
                    refusal = vsi_pkg::REFUSE_OK;

                nav_quiet_next   = 16'd0;
                nav_contact_next = 1'b1;
                if (refusal == vsi_pkg::REFUSE_OK)
                begin
                    approved = 1'b1;
                    if (approve_count_reg != vsi_pkg::SAT32)
                        approve_count_next = approve_count_reg + 32'd1;
                end
                else
                begin
                    if (reject_count_reg != vsi_pkg::SAT32)
                        reject_count_next = reject_count_reg + 32'd1;
                    // speed, steering and sensor refusals start a recovery hold
                    if (refusal == vsi_pkg::REFUSE_OVERSPEED ||
                        refusal == vsi_pkg::REFUSE_OVERSTEER ||
                        refusal == vsi_pkg::REFUSE_SENSOR)
                    begin
                        recovering_next = 1'b1;
                        hold_left_next  = hold_ms_reg;
                    end
                end
            end
            vsi_pkg::KIND_SENSOR:
            begin
                snap_imu_next     = in_imu_reg;
                snap_ranger_next  = in_ranger_reg;
                snap_dist_next    = in_distance_reg;
                sensor_seen_next  = 1'b1;
                sensor_quiet_next = 16'd0;
                if (in_shaking_reg && !shake_wait_reg && !lock_flag_reg)
                begin
                    shake_wait_next = 1'b1;
                    rest_left_next  = rest_limit_reg;
                    notice[vsi_pkg::NOTICE_SLOW] = 1'b1;
                end
                else if (!in_shaking_reg && shake_wait_reg)
                begin
                    shake_wait_next = 1'b0;
                    rest_left_next  = 16'd0;
                    notice[vsi_pkg::NOTICE_RESUME] = 1'b1;
                end
            end
            default: ;
        endcase

        if (lock_flag_next)
            mode = vsi_pkg::MODE_LOCKED;
        else if (shake_wait_next)
            mode = vsi_pkg::MODE_SHAKING;
        else if (recovering_next)
            mode = vsi_pkg::MODE_RECOVERY;
        else if (!sensor_seen_next)
            mode = vsi_pkg::MODE_NO_SENSOR;
        else
            mode = vsi_pkg::MODE_NORMAL;

        out_data_next = {3'd0, reject_count_next, approve_count_next, mode,
                         (hold_left_next != 16'd0), alive, notice, refusal, approved};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nav_contact_reg   <= 1'b0;
            sensor_seen_reg   <= 1'b0;
            recovering_reg    <= 1'b0;
            shake_wait_reg    <= 1'b0;
            lock_flag_reg     <= 1'b0;
            snap_imu_reg      <= 1'b0;
            snap_ranger_reg   <= 1'b0;
            snap_dist_reg     <= 16'd0;
            nav_quiet_reg     <= 16'd0;
            sensor_quiet_reg  <= 16'd0;
            check_phase_reg   <= 16'd0;
            rest_left_reg     <= 16'd0;
            hold_left_reg     <= 16'd0;
            approve_count_reg <= 32'd0;
            reject_count_reg  <= 32'd0;
        end
        else if (advance)
        begin
            nav_contact_reg   <= nav_contact_next;
            sensor_seen_reg   <= sensor_seen_next;
            recovering_reg    <= recovering_next;
            shake_wait_reg    <= shake_wait_next;
            lock_flag_reg     <= lock_flag_next;
            snap_imu_reg      <= snap_imu_next;
            snap_ranger_reg   <= snap_ranger_next;
            snap_dist_reg     <= snap_dist_next;
            nav_quiet_reg     <= nav_quiet_next;
            sensor_quiet_reg  <= sensor_quiet_next;
            check_phase_reg   <= check_phase_next;
            rest_left_reg     <= rest_left_next;
            hold_left_reg     <= hold_left_next;
            approve_count_reg <= approve_count_next;
            reject_count_reg  <= reject_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the vehicle safety interlock unit.
module testbench;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam logic [2:0] REG_SPARE     = 3'd7;
    localparam int MAX_WAIT     = 18;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 630;
    localparam int ROUNDS       = 3;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] speed;
        logic [15:0] steering;
        logic        imu_ok;
        logic        ranger_ok;
        logic [15:0] distance;
        logic        shaking;
    } inbound_t;

    typedef struct {
        logic              approved;
        vsi_pkg::refusal_t refusal;
        logic [3:0]        notice;
        logic              alive;
        logic              lamp;
        vsi_pkg::mode_t    mode;
        logic [31:0]       approved_total;
        logic [31:0]       rejected_total;
    } outcome_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [vsi_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic [2:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [vsi_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [2:0]                     cfg_addr  = '0;
    logic [15:0]                    cfg_data  = '0;

    outcome_t expected_outcomes[$];
    int       errors = 0;
    int       quiet_cycles = 0;
    int       sink_hold_cycles = 0;
    bit       steady = 1'b0;

    // predictor copy of the limits
    logic [14:0] lim_speed, lim_steer;
    logic [15:0] min_gap, silence_ms, period_ms, rest_len_ms, hold_len_ms;
    // predictor copy of the supervisor state
    logic        nav_linked, sensor_live, held_back, awaiting_rest, locked_out;
    logic        snap_imu, snap_ranger;
    logic [15:0] snap_distance;
    logic [15:0] nav_silent_ms, sensor_silent_ms, phase_ms, rest_left, hold_left;
    logic [31:0] n_approved, n_rejected;

    vehicle_safety_interlock_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // ---------------- predictor ----------------

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == vsi_pkg::SAT16) ? v : v + 16'd1;
    endfunction

    task automatic reset_interlock_model();
        lim_speed     = vsi_pkg::SPEED_LIMIT_RST;
        lim_steer     = vsi_pkg::STEERING_LIMIT_RST;
        min_gap       = vsi_pkg::MIN_DISTANCE_RST;
        silence_ms    = vsi_pkg::SILENCE_LIMIT_RST;
        period_ms     = vsi_pkg::CHECK_PERIOD_RST;
        rest_len_ms   = vsi_pkg::REST_LIMIT_RST;
        hold_len_ms   = vsi_pkg::HOLD_RST;
        nav_linked    = 1'b0;
        sensor_live   = 1'b0;
        held_back     = 1'b0;
        awaiting_rest = 1'b0;
        locked_out    = 1'b0;
        snap_imu      = 1'b0;
        snap_ranger   = 1'b0;
        snap_distance = '0;
        nav_silent_ms = '0;
        sensor_silent_ms = '0;
        phase_ms      = '0;
        rest_left     = '0;
        hold_left     = '0;
        n_approved    = '0;
        n_rejected    = '0;
    endtask

    function automatic vsi_pkg::refusal_t judge_command(input logic [15:0] speed,
                                                        input logic [15:0] steering);
        int spd;
        int steer;
        int lim;
        spd   = $signed(speed);
        steer = $signed(steering);
        lim   = lim_steer;
        if (locked_out)
            return vsi_pkg::REFUSE_LOCKED;
        if (held_back)
            return vsi_pkg::REFUSE_RECOVERY;
        if (spd > int'(lim_speed))
            return vsi_pkg::REFUSE_OVERSPEED;
        if (steer > lim || steer < -lim)
            return vsi_pkg::REFUSE_OVERSTEER;
        if (!sensor_live || !snap_imu || !snap_ranger || snap_distance <= min_gap)
            return vsi_pkg::REFUSE_SENSOR;
        return vsi_pkg::REFUSE_OK;
    endfunction

    task automatic start_hold();
        held_back = 1'b1;
        hold_left = hold_len_ms;
    endtask

    task automatic predict_outcome(input inbound_t ev, output outcome_t st);
        st.approved = 1'b0;
        st.refusal  = vsi_pkg::REFUSE_OK;
        st.notice   = '0;
        st.alive    = 1'b0;
        case (ev.kind)
            vsi_pkg::KIND_TICK:
            begin
                nav_silent_ms    = bump16(nav_silent_ms);
                sensor_silent_ms = bump16(sensor_silent_ms);
                phase_ms         = bump16(phase_ms);
                if (rest_left != 0)
                begin
                    rest_left = rest_left - 16'd1;
                    if (rest_left == 0 && awaiting_rest)
                    begin
                        awaiting_rest = 1'b0;
                        locked_out    = 1'b1;
                        st.notice[vsi_pkg::NOTICE_LOCK] = 1'b1;
                    end
                end
                if (hold_left != 0)
                begin
                    hold_left = hold_left - 16'd1;
                    if (hold_left == 0)
                        held_back = 1'b0;
                end
                if (phase_ms >= period_ms)
                begin
                    phase_ms = '0;
                    st.alive = 1'b1;
                    if (awaiting_rest || locked_out || !sensor_live)
                        hold_left = hold_len_ms;
                    if (nav_linked && nav_silent_ms > silence_ms)
                    begin
                        start_hold();
                        nav_linked = 1'b0;
                    end
                    if (sensor_live && sensor_silent_ms > silence_ms)
                    begin
                        start_hold();
                        st.notice[vsi_pkg::NOTICE_STOP] = 1'b1;
                        sensor_live = 1'b0;
                    end
                end
            end
            vsi_pkg::KIND_NAV_BEAT:
            begin
                nav_silent_ms = '0;
                nav_linked    = 1'b1;
            end
            vsi_pkg::KIND_NAV_EXIT:
                nav_linked = 1'b0;
            vsi_pkg::KIND_NAV_CMD:
            begin
                st.refusal    = judge_command(ev.speed, ev.steering);
                nav_silent_ms = '0;
                nav_linked    = 1'b1;
                if (st.refusal == vsi_pkg::REFUSE_OK)
                begin
                    st.approved = 1'b1;
                    if (n_approved != vsi_pkg::SAT32)
                        n_approved = n_approved + 32'd1;
                end
                else
                begin
                    if (n_rejected != vsi_pkg::SAT32)
                        n_rejected = n_rejected + 32'd1;
                    if (st.refusal < vsi_pkg::REFUSE_RECOVERY)
                        start_hold();
                end
            end
            vsi_pkg::KIND_SENSOR:
            begin
                snap_imu         = ev.imu_ok;
                snap_ranger      = ev.ranger_ok;
                snap_distance    = ev.distance;
                sensor_live      = 1'b1;
                sensor_silent_ms = '0;
                if (ev.shaking && !awaiting_rest && !locked_out)
                begin
                    awaiting_rest = 1'b1;
                    rest_left     = rest_len_ms;
                    st.notice[vsi_pkg::NOTICE_SLOW] = 1'b1;
                end
                else if (!ev.shaking && awaiting_rest)
                begin
                    awaiting_rest = 1'b0;
                    rest_left     = '0;
                    st.notice[vsi_pkg::NOTICE_RESUME] = 1'b1;
                end
            end
            default: ;
        endcase
        if (locked_out)
            st.mode = vsi_pkg::MODE_LOCKED;
        else if (awaiting_rest)
            st.mode = vsi_pkg::MODE_SHAKING;
        else if (held_back)
            st.mode = vsi_pkg::MODE_RECOVERY;
        else if (!sensor_live)
            st.mode = vsi_pkg::MODE_NO_SENSOR;
        else
            st.mode = vsi_pkg::MODE_NORMAL;
        st.lamp           = (hold_left != 0);
        st.approved_total = n_approved;
        st.rejected_total = n_rejected;
    endtask

    // ---------------- drivers ----------------

    function automatic inbound_t make_event(input logic [2:0] kind,
                                            input logic [15:0] speed = '0,
                                            input logic [15:0] steering = '0,
                                            input logic imu_ok = 1'b0,
                                            input logic ranger_ok = 1'b0,
                                            input logic [15:0] distance = '0,
                                            input logic shaking = 1'b0);
        inbound_t ev;
        ev.kind      = kind;
        ev.speed     = speed;
        ev.steering  = steering;
        ev.imu_ok    = imu_ok;
        ev.ranger_ok = ranger_ok;
        ev.distance  = distance;
        ev.shaking   = shaking;
        return ev;
    endfunction

    task automatic send_event(input inbound_t ev);
        int gap;
        outcome_t st;
        gap = steady ? 0 : int'($urandom_range(0, MAX_WAIT));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.kind;
        s_tdata  <= {{(vsi_pkg::IN_DATA_W - 51){1'b0}}, ev.shaking, ev.distance,
                     ev.ranger_ok, ev.imu_ok, ev.steering, ev.speed};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_outcome(ev, st);
        expected_outcomes.push_back(st);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_event(make_event(vsi_pkg::KIND_TICK));
    endtask

    task automatic send_command(input logic [15:0] speed, input logic [15:0] steering);
        send_event(make_event(vsi_pkg::KIND_NAV_CMD, speed, steering));
    endtask

    task automatic send_sensor(input logic imu_ok, input logic ranger_ok,
                               input logic [15:0] distance, input logic shaking);
        send_event(make_event(vsi_pkg::KIND_SENSOR, '0, '0, imu_ok, ranger_ok,
                              distance, shaking));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_valid high so that writes can follow back to back
    task automatic set_register(input logic [2:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            vsi_pkg::REG_SPEED_LIMIT:    lim_speed   = value[14:0];
            vsi_pkg::REG_STEERING_LIMIT: lim_steer   = value[14:0];
            vsi_pkg::REG_MIN_DISTANCE:   min_gap     = value;
            vsi_pkg::REG_SILENCE_LIMIT:  silence_ms  = value;
            vsi_pkg::REG_CHECK_PERIOD:   period_ms   = value;
            vsi_pkg::REG_REST_LIMIT:     rest_len_ms = value;
            vsi_pkg::REG_HOLD:           hold_len_ms = value;
            default: ;
        endcase
    endtask

    task automatic release_cfg_port();
        cfg_valid <= 1'b0;
    endtask

    // ---------------- result side ----------------

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_outcome(input logic [vsi_pkg::OUT_DATA_W-1:0] word);
        outcome_t want;
        if (expected_outcomes.size() == 0)
        begin
            $error("result with nothing expected: %h", word);
            errors++;
            return;
        end
        want = expected_outcomes.pop_front();
        compare_field("approved", 32'(want.approved), 32'(word[0]));
        compare_field("refusal", 32'(want.refusal), 32'(word[3:1]));
        compare_field("nav_notice", 32'(want.notice), 32'(word[7:4]));
        compare_field("alive_pulse", 32'(want.alive), 32'(word[8]));
        compare_field("safe_lamp", 32'(want.lamp), 32'(word[9]));
        compare_field("mode", 32'(want.mode), 32'(word[12:10]));
        compare_field("approved_total", want.approved_total, word[44:13]);
        compare_field("rejected_total", want.rejected_total, word[76:45]);
    endtask

    initial
    begin : result_sink
        int stall;
        forever
        begin
            stall = steady ? 0 : int'($urandom_range(0, MAX_WAIT));
            if (sink_hold_cycles > 0)
            begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            check_outcome(m_tdata);
        end
    end

    // ---------------- random stimulus ----------------

    function automatic logic [15:0] in_band(input logic [14:0] limit);
        int span;
        int v;
        span = limit;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
    endfunction

    function automatic inbound_t random_event();
        inbound_t ev;
        int pick;
        ev.kind      = vsi_pkg::KIND_TICK;
        ev.speed     = 16'($urandom);
        ev.steering  = 16'($urandom);
        ev.imu_ok    = 1'($urandom);
        ev.ranger_ok = 1'($urandom);
        ev.distance  = 16'($urandom);
        ev.shaking   = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            ev.kind = vsi_pkg::KIND_TICK;
        else if (pick < 62)
        begin
            ev.kind = vsi_pkg::KIND_NAV_CMD;
            if ($urandom_range(0, 4) != 0)
            begin
                ev.speed    = in_band(lim_speed);
                ev.steering = in_band(lim_steer);
            end
        end
        else if (pick < 82)
        begin
            ev.kind    = vsi_pkg::KIND_SENSOR;
            ev.shaking = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 4) != 0)
            begin
                ev.imu_ok    = 1'b1;
                ev.ranger_ok = 1'b1;
                if (min_gap != vsi_pkg::SAT16)
                    ev.distance = 16'($urandom_range(int'(min_gap) + 1, 65535));
            end
        end
        else if (pick < 92)
            ev.kind = vsi_pkg::KIND_NAV_BEAT;
        else if (pick < 97)
            ev.kind = vsi_pkg::KIND_NAV_EXIT;
        else
            ev.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        return ev;
    endfunction

    // short timers so that holds, checks and silences come round often;
    // the rest limit is either off or too long to run out here
    task automatic choose_random_limits();
        set_register(vsi_pkg::REG_SPEED_LIMIT, 16'($urandom_range(0, 32767)));
        set_register(vsi_pkg::REG_STEERING_LIMIT, 16'($urandom_range(0, 32767)));
        set_register(vsi_pkg::REG_MIN_DISTANCE, 16'($urandom_range(0, 8000)));
        set_register(vsi_pkg::REG_SILENCE_LIMIT, 16'($urandom_range(1, 24)));
        set_register(vsi_pkg::REG_CHECK_PERIOD, 16'($urandom_range(1, 8)));
        set_register(vsi_pkg::REG_REST_LIMIT,
                     $urandom_range(0, 1) ? vsi_pkg::SAT16 : 16'd0);
        set_register(vsi_pkg::REG_HOLD, 16'($urandom_range(1, 12)));
        release_cfg_port();
    endtask

    // ---------------- tests ----------------

    task automatic check_defaults();
        for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
            send_event(make_event(k[2:0], 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1));
        send_ticks(1);
        send_event(make_event(vsi_pkg::KIND_NAV_BEAT));
        send_event(make_event(vsi_pkg::KIND_NAV_EXIT));
        send_sensor(1'b1, 1'b1, 16'hFFFF, 1'b0);
        send_command(16'd512, 16'd6400);
        send_command(16'h8000, 16'hE700);
        send_command(16'd0, 16'd0);
    endtask

    task automatic check_refusal_reasons();
        wait_results_drained();
        set_register(vsi_pkg::REG_HOLD, 16'd1);
        set_register(vsi_pkg::REG_CHECK_PERIOD, vsi_pkg::SAT16);
        release_cfg_port();
        send_command(16'd0, 16'd6401);
        send_command(16'd0, 16'd0);        // still held
        send_ticks(1);
        send_command(16'd0, 16'hE6FF);
        send_ticks(1);
        send_command(16'h7FFF, 16'd0);
        send_ticks(1);
        send_sensor(1'b0, 1'b1, 16'hFFFF, 1'b0);
        send_command(16'd0, 16'd0);
        send_ticks(1);
        send_sensor(1'b1, 1'b0, 16'hFFFF, 1'b0);
        send_command(16'd0, 16'd0);
        send_ticks(1);
        send_sensor(1'b1, 1'b1, 16'd160, 1'b0);
        send_command(16'd0, 16'd0);
        send_ticks(1);
        send_sensor(1'b1, 1'b1, 16'd161, 1'b0);
        send_command(16'd0, 16'h8000);
        send_ticks(1);
    endtask

    task automatic check_register_extremes();
        wait_results_drained();
        set_register(vsi_pkg::REG_SPEED_LIMIT, 16'hFFFF);     // top bit is dropped
        set_register(vsi_pkg::REG_STEERING_LIMIT, 16'h7FFF);
        set_register(vsi_pkg::REG_MIN_DISTANCE, 16'h0000);
        set_register(REG_SPARE, 16'h1234);                    // no such register
        release_cfg_port();
        send_sensor(1'b1, 1'b1, 16'd0, 1'b0);
        send_command(16'h7FFF, 16'h8001);
        send_ticks(1);
        send_sensor(1'b1, 1'b1, 16'd1, 1'b0);
        send_command(16'h7FFF, 16'h8001);
        send_command(16'h7FFF, 16'h8000);
        send_ticks(1);
        wait_results_drained();
        set_register(vsi_pkg::REG_SPEED_LIMIT, 16'd0);
        set_register(vsi_pkg::REG_STEERING_LIMIT, 16'd0);
        set_register(vsi_pkg::REG_MIN_DISTANCE, vsi_pkg::SAT16);
        release_cfg_port();
        send_command(16'd0, 16'd0);
        send_ticks(1);
        send_command(16'd1, 16'd0);
        send_ticks(1);
        send_command(16'hFFFF, 16'd1);
        send_ticks(1);
    endtask

    task automatic check_zero_timers();
        wait_results_drained();
        set_register(vsi_pkg::REG_SPEED_LIMIT, 16'd512);
        set_register(vsi_pkg::REG_STEERING_LIMIT, 16'd6400);
        set_register(vsi_pkg::REG_MIN_DISTANCE, 16'd160);
        set_register(vsi_pkg::REG_CHECK_PERIOD, 16'd0);
        set_register(vsi_pkg::REG_HOLD, 16'd0);
        set_register(vsi_pkg::REG_REST_LIMIT, 16'd0);
        set_register(vsi_pkg::REG_SILENCE_LIMIT, 16'd1);
        release_cfg_port();
        send_ticks(2);                              // a check on every tick
        send_sensor(1'b1, 1'b1, 16'd4000, 1'b1);    // rest timer never starts
        send_ticks(3);
        send_sensor(1'b1, 1'b1, 16'd4000, 1'b0);
        send_command(16'h7FFF, 16'd0);              // recovery with no hold to end it
        send_ticks(4);                              // both partners fall silent
        send_command(16'd0, 16'd0);
        wait_results_drained();
        set_register(vsi_pkg::REG_HOLD, 16'd2);
        set_register(vsi_pkg::REG_CHECK_PERIOD, 16'd1);
        set_register(vsi_pkg::REG_SILENCE_LIMIT, 16'd100);
        release_cfg_port();
        send_ticks(1);
        send_sensor(1'b1, 1'b1, 16'd4000, 1'b0);
        send_ticks(2);
        send_command(16'd0, 16'd0);
    endtask

    // widest limits: a long hold keeps the lamp on, the silence limit is never passed
    task automatic check_timer_saturation();
        wait_results_drained();
        set_register(vsi_pkg::REG_SILENCE_LIMIT, vsi_pkg::SAT16);
        set_register(vsi_pkg::REG_CHECK_PERIOD, 16'd4096);
        set_register(vsi_pkg::REG_HOLD, vsi_pkg::SAT16);
        release_cfg_port();
        steady = 1'b1;
        send_sensor(1'b1, 1'b1, 16'hFFFF, 1'b0);
        send_command(16'd513, 16'd0);               // longest hold
        send_ticks(32);
        wait_results_drained();
        set_register(vsi_pkg::REG_SILENCE_LIMIT, vsi_pkg::SAT16 - 16'd1);
        set_register(vsi_pkg::REG_CHECK_PERIOD, 16'd1);
        set_register(vsi_pkg::REG_HOLD, 16'd2);
        release_cfg_port();
        send_ticks(2);
        send_command(16'd0, 16'd0);
        steady = 1'b0;
    endtask

    task automatic check_random_traffic();
        for (int round = 0; round < ROUNDS; round++)
        begin
            wait_results_drained();
            choose_random_limits();
            for (int n = 0; n < RANDOM_ITEMS / ROUNDS; n++)
            begin
                if (n % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                if (round == 1 && n == 100)
                begin
                    // receiver holds off while items keep coming
                    steady = 1'b1;
                    sink_hold_cycles = 80;
                end
                if (round == 1 && n == 170)
                    wait_results_drained();
                send_event(random_event());
            end
        end
        steady = 1'b0;
    endtask

    task automatic check_lockout();
        wait_results_drained();
        set_register(vsi_pkg::REG_REST_LIMIT, 16'd3);
        set_register(vsi_pkg::REG_CHECK_PERIOD, 16'd2);
        set_register(vsi_pkg::REG_HOLD, 16'd2);
        set_register(vsi_pkg::REG_SILENCE_LIMIT, 16'd100);
        release_cfg_port();
        send_sensor(1'b1, 1'b1, 16'hFFFF, 1'b0);
        send_sensor(1'b1, 1'b1, 16'hFFFF, 1'b1);
        send_ticks(4);                              // no rest in time: locks
        send_command(16'd0, 16'd0);
        send_sensor(1'b1, 1'b1, 16'hFFFF, 1'b1);    // no slow notice once locked
        send_sensor(1'b1, 1'b1, 16'hFFFF, 1'b0);
        send_event(make_event(vsi_pkg::KIND_NAV_BEAT));
        send_ticks(2);
        send_command(16'd0, 16'd0);
    endtask

    initial
    begin
        reset_interlock_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        check_defaults();
        check_refusal_reasons();
        check_register_extremes();
        check_zero_timers();
        check_timer_saturation();
        check_random_traffic();
        check_lockout();
        wait_results_drained();
        repeat (8) @(posedge clk);
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
